// ===== rtl/char_lcd_cursor_controller_assert.svh =====
// assertion macros for the character display cursor controller
// expects clk_i and rst_ni in the scope of the including module
`ifndef CHAR_LCD_CURSOR_CONTROLLER_ASSERT_SVH
`define CHAR_LCD_CURSOR_CONTROLLER_ASSERT_SVH

// same-cycle implication, off during reset
`define CLCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/clcd_pkg.sv =====
// shared types and codes for the character display cursor controller
// no dependencies
package clcd_pkg;

  typedef enum logic {
    CMD_PUT  = 1'b0,
    CMD_GOTO = 1'b1
  } cmd_e;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] SET_ADDR    = 8'h80;

  localparam int unsigned FIELD_W    = 8;
  localparam int unsigned CURSOR_W   = 7;

endpackage

// ===== rtl/char_lcd_cursor_controller.sv =====
// cursor controller for a rows x columns character display
// the first display write passes through the request register, then the result register
// throughput: one write per cycle while out_stall_i is low; a request issues one to three writes,
// set by its write count (goto/return/tab 1, char 2, backspace 3 off column 0, else 1)
// reset: cursor to row 0 column 0, both pipeline registers empty
// depends on clcd_pkg and char_lcd_cursor_controller_assert.svh
module char_lcd_cursor_controller #(
  parameter int unsigned COLUMNS    = 20,
  parameter int unsigned ROWS       = 4,
  parameter int unsigned ROW_STRIDE = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] target_row_i,
  input  logic [7:0] target_col_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_data_o,
  output logic [7:0] bus_byte_o,
  output logic [6:0] cursor_now_o,
  output logic       last_o
);

  localparam int unsigned IN_MAX  = (1 << clcd_pkg::FIELD_W) - 1;
  localparam int unsigned IN_N    = IN_MAX + 1;
  localparam int unsigned COL_W   = $clog2(COLUMNS);
  localparam int unsigned ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned QMAX    = IN_MAX / COLUMNS;
  localparam int unsigned Q_W     = $clog2(QMAX + 1);
  localparam int unsigned SMAX    = ROWS - 1 + QMAX;
  localparam int unsigned S_W     = $clog2(SMAX + 1);
  localparam int unsigned LIN_W   = $clog2(ROWS * COLUMNS);
  localparam int unsigned X_W     = LIN_W + clcd_pkg::CURSOR_W;
  localparam int unsigned A_W     = $clog2((ROWS - 1) * ROW_STRIDE + COLUMNS)
                                    + clcd_pkg::FIELD_W;
  localparam int unsigned TAB_COL = COLUMNS / 2;

  typedef logic [COL_W-1:0] col_tab_t [IN_N];
  typedef logic [Q_W-1:0]   quo_tab_t [IN_N];
  typedef logic [ROW_W-1:0] row_tab_t [IN_N];
  typedef logic [ROW_W-1:0] sum_tab_t [SMAX+1];

  // elaboration-time tables, built by counting with wrap
  function automatic col_tab_t build_col_mod();
    col_tab_t t;
    int unsigned c;
    c = 0;
    for (int unsigned i = 0; i < IN_N; i++) begin
      t[i] = COL_W'(c);
      c = (c == COLUMNS - 1) ? 0 : c + 1;
    end
    return t;
  endfunction

  function automatic quo_tab_t build_col_quo();
    quo_tab_t t;
    int unsigned c;
    int unsigned q;
    c = 0;
    q = 0;
    for (int unsigned i = 0; i < IN_N; i++) begin
      t[i] = Q_W'(q);
      if (c == COLUMNS - 1) begin
        c = 0;
        q = q + 1;
      end else begin
        c = c + 1;
      end
    end
    return t;
  endfunction

  function automatic row_tab_t build_row_mod();
    row_tab_t t;
    int unsigned r;
    r = 0;
    for (int unsigned i = 0; i < IN_N; i++) begin
      t[i] = ROW_W'(r);
      r = (r == ROWS - 1) ? 0 : r + 1;
    end
    return t;
  endfunction

  function automatic sum_tab_t build_sum_mod();
    sum_tab_t t;
    int unsigned r;
    r = 0;
    for (int unsigned i = 0; i <= SMAX; i++) begin
      t[i] = ROW_W'(r);
      r = (r == ROWS - 1) ? 0 : r + 1;
    end
    return t;
  endfunction

  localparam col_tab_t COL_MOD = build_col_mod();
  localparam quo_tab_t COL_QUO = build_col_quo();
  localparam row_tab_t ROW_MOD = build_row_mod();
  localparam sum_tab_t SUM_MOD = build_sum_mod();

  // request register
  logic               item_valid_q, item_valid_d;
  clcd_pkg::cmd_e     cmd_q;
  logic [7:0]         char_q;
  logic [COL_W-1:0]   gcol_q;
  logic [S_W-1:0]     gsum_q;
  logic [1:0]         seq_q, seq_d;

  // cursor
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic               is_data_q, is_data_d;
  logic [7:0]         bus_q, bus_d;
  logic [6:0]         cur_now_q, cur_now_d;
  logic               last_q, last_d;

  logic               in_take;
  logic               out_free;
  logic               emit;
  logic               done;
  logic               is_goto, is_cr, is_bs, is_tab, is_print, bs_move;
  logic               col_last, row_last;
  logic [ROW_W-1:0]   row_next;
  logic [ROW_W-1:0]   row_n;
  logic [COL_W-1:0]   col_n;
  logic [1:0]         n_items;
  logic               last_k;
  logic [X_W-1:0]     lin_old, lin_new;
  logic [A_W-1:0]     addr_new;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = item_valid_q && out_free;
  assign done       = emit && last_k;
  assign in_stall_o = item_valid_q && !done;
  assign in_take    = in_valid_i && !in_stall_o;

  // request decode
  assign is_goto  = (cmd_q == clcd_pkg::CMD_GOTO);
  assign is_cr    = !is_goto && (char_q == clcd_pkg::CH_CR);
  assign is_bs    = !is_goto && (char_q == clcd_pkg::CH_BS);
  assign is_tab   = !is_goto && (char_q == clcd_pkg::CH_TAB);
  assign is_print = !is_goto && !is_cr && !is_bs && !is_tab;
  assign bs_move  = is_bs && (col_q != '0);

  assign col_last = (col_q == COL_W'(COLUMNS - 1));
  assign row_last = (row_q == ROW_W'(ROWS - 1));
  assign row_next = row_last ? '0 : row_q + ROW_W'(1);

  // next cursor position
  always_comb begin
    row_n = row_q;
    col_n = col_q;
    if (is_goto) begin
      row_n = SUM_MOD[gsum_q];
      col_n = gcol_q;
    end else if (is_print) begin
      if (col_last) begin
        row_n = row_next;
        col_n = '0;
      end else begin
        col_n = col_q + COL_W'(1);
      end
    end else if (is_cr) begin
      row_n = row_next;
      col_n = '0;
    end else if (is_bs) begin
      if (bs_move) begin
        col_n = col_q - COL_W'(1);
      end
    end else begin
      if (row_last && (col_q >= COL_W'(TAB_COL))) begin
        row_n = '0;
        col_n = '0;
      end else if (col_q < COL_W'(TAB_COL)) begin
        col_n = COL_W'(TAB_COL);
      end else begin
        row_n = row_next;
        col_n = '0;
      end
    end
  end

  always_comb begin
    if (is_print) begin
      n_items = 2'd2;
    end else if (bs_move) begin
      n_items = 2'd3;
    end else begin
      n_items = 2'd1;
    end
  end

  assign last_k   = (seq_q == n_items - 2'd1);
  assign lin_old  = X_W'(row_q) * X_W'(COLUMNS) + X_W'(col_q);
  assign lin_new  = X_W'(row_n) * X_W'(COLUMNS) + X_W'(col_n);
  assign addr_new = A_W'(row_n) * A_W'(ROW_STRIDE) + A_W'(col_n);

  // write selection for the current step
  always_comb begin
    is_data_d = 1'b0;
    bus_d     = clcd_pkg::SET_ADDR | addr_new[7:0];
    cur_now_d = lin_new[6:0];
    last_d    = last_k;
    if (is_print && (seq_q == 2'd0)) begin
      is_data_d = 1'b1;
      bus_d     = char_q;
      cur_now_d = lin_old[6:0];
    end else if (bs_move && (seq_q == 2'd1)) begin
      is_data_d = 1'b1;
      bus_d     = clcd_pkg::CH_SPACE;
    end
  end

  assign item_valid_d = in_take || (item_valid_q && !done);
  assign out_valid_d  = emit || (out_valid_q && out_stall_i);
  assign row_d        = done ? row_n : row_q;
  assign col_d        = done ? col_n : col_q;

  always_comb begin
    seq_d = seq_q;
    if (done) begin
      seq_d = 2'd0;
    end else if (emit) begin
      seq_d = seq_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      seq_q        <= 2'd0;
      row_q        <= '0;
      col_q        <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
      seq_q        <= seq_d;
      row_q        <= row_d;
      col_q        <= col_d;
    end
  end

  // goto folding starts here: column split and row partial sum
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= clcd_pkg::cmd_e'(cmd_i);
      char_q <= char_code_i;
      gcol_q <= COL_MOD[target_col_i];
      gsum_q <= S_W'(ROW_MOD[target_row_i]) + S_W'(COL_QUO[target_col_i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      is_data_q <= is_data_d;
      bus_q     <= bus_d;
      cur_now_q <= cur_now_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_data_o    = is_data_q;
  assign bus_byte_o   = bus_q;
  assign cursor_now_o = cur_now_q;
  assign last_o       = last_q;

`include "char_lcd_cursor_controller_assert.svh"

  `CLCD_ASSERT_NOW(a_cursor_range, 1'b1,
    (row_q <= ROW_W'(ROWS - 1)) && (col_q <= COL_W'(COLUMNS - 1)),
    "cursor outside display")
  `CLCD_ASSERT_NOW(a_seq_range, item_valid_q, seq_q < n_items,
    "write step beyond request's write count")
  `CLCD_ASSERT_NEXT(a_emit_shows, emit, out_valid_q && (last_q == $past(last_k)),
    "issued write not held in result register")
  `CLCD_ASSERT_NEXT(a_cursor_hold, !done, $stable(row_q) && $stable(col_q),
    "cursor moved without finishing a request")

endmodule
